// ===== hdl/imc_pkg.sv =====
`timescale 1ns / 1ps

package imc_pkg;

  localparam int unsigned CAL_SAMPLES_DEF = 512;
  localparam int unsigned CAL_SHIFT       = 9;
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned SUM_W           = 25;
  localparam int unsigned NUM_AXES        = 3;

  typedef enum logic [1:0] {
    OP_GYRO        = 2'd0,
    OP_ACCEL       = 2'd1,
    OP_START_ALL   = 2'd2,
    OP_START_ACCEL = 2'd3
  } imc_op_e;

  typedef logic signed [SAMPLE_W-1:0] imc_sample_t;
  typedef logic [NUM_AXES-1:0][SAMPLE_W-1:0] imc_axes_t;

  typedef struct packed {
    logic [1:0]  op;
    imc_sample_t sample_x;
    imc_sample_t sample_y;
    imc_sample_t sample_z;
  } imc_in_t;

  typedef struct packed {
    imc_sample_t roll_value;
    imc_sample_t pitch_value;
    imc_sample_t yaw_value;
    logic        gyro_cal_done;
    logic        accel_cal_done;
  } imc_out_t;

  // offsets held now and offsets as updated by the current sample
  typedef struct packed {
    imc_axes_t offset;
    imc_axes_t offset_upd;
  } imc_cal_t;

  // per-sensor calibration control from the sample counters
  typedef struct packed {
    logic en;
    logic clear;
    logic zero_yaw;
  } imc_cal_ctrl_t;

endpackage

// ===== hdl/imc_sensor_cal.sv =====
`timescale 1ns / 1ps

module imc_sensor_cal (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imc_pkg::imc_cal_ctrl_t ctrl_i,
  input  imc_pkg::imc_axes_t    axis_i,
  output imc_pkg::imc_cal_t     cal_o
);

  logic [imc_pkg::NUM_AXES-1:0][imc_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [imc_pkg::NUM_AXES-1:0][imc_pkg::SAMPLE_W-1:0] offset_q, offset_d;

  always_comb begin
    for (int i = 0; i < imc_pkg::NUM_AXES; i++) begin
      sum_d[i] = (ctrl_i.clear ? '0 : sum_q[i])
               + {{(imc_pkg::SUM_W - imc_pkg::SAMPLE_W){axis_i[i][imc_pkg::SAMPLE_W-1]}},
                  axis_i[i]};
      offset_d[i] = sum_d[i][imc_pkg::CAL_SHIFT +: imc_pkg::SAMPLE_W];
    end
    // yaw zero is dropped when the final calibration sample lands
    if (ctrl_i.zero_yaw) begin
      offset_d[imc_pkg::NUM_AXES-1] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      offset_q <= '0;
    end else if (ctrl_i.en) begin
      sum_q    <= sum_d;
      offset_q <= offset_d;
    end
  end

  assign cal_o.offset     = offset_q;
  assign cal_o.offset_upd = offset_d;

endmodule

// ===== hdl/imu_offset_calibration.sv =====
`timescale 1ns / 1ps
// path: input register, then result register, from input transfer to result valid
// throughput: one item per cycle unless the output stalls; the input register holds its item
// while the result register is full and out_ready_i is low; an item's counter, sum and yaw-zero
// updates take effect in the cycle it leaves the input register
// reset: gyro calibration pending for CAL_SAMPLES samples, accel calibrated with zero offsets

module imu_offset_calibration #(
  parameter int unsigned CAL_SAMPLES = imc_pkg::CAL_SAMPLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  imc_pkg::imc_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output imc_pkg::imc_out_t  out_data_o
);

  localparam int unsigned CntW = $clog2(CAL_SAMPLES + 1);
  localparam logic [CntW-1:0] CalLoad = CntW'(CAL_SAMPLES);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  imc_pkg::imc_in_t  in_q;
  logic              in_valid_q;
  imc_pkg::imc_out_t out_q, out_d;
  logic              out_valid_q;
  logic              out_free;
  logic              s1_fire;

  logic [CntW-1:0] gyro_left_q, gyro_left_d;
  logic [CntW-1:0] accel_left_q, accel_left_d;
  logic            gyro_cal, accel_cal;

  imc_pkg::imc_cal_ctrl_t gyro_ctrl, accel_ctrl;
  imc_pkg::imc_cal_t      gyro_st, accel_st;
  imc_pkg::imc_axes_t     gyro_axis, accel_axis, res_axis;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (s1_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // sensor-frame to roll/pitch/yaw remap
  assign gyro_axis  = {in_q.sample_z, in_q.sample_y, in_q.sample_x};
  assign accel_axis = {in_q.sample_z, -in_q.sample_x, in_q.sample_y};

  assign gyro_cal  = gyro_left_q != '0;
  assign accel_cal = accel_left_q != '0;

  always_comb begin
    gyro_ctrl.en        = s1_fire && (in_q.op == imc_pkg::OP_GYRO) && gyro_cal;
    gyro_ctrl.clear     = gyro_left_q == CalLoad;
    gyro_ctrl.zero_yaw  = 1'b0;
    accel_ctrl.en       = s1_fire && (in_q.op == imc_pkg::OP_ACCEL) && accel_cal;
    accel_ctrl.clear    = accel_left_q == CalLoad;
    accel_ctrl.zero_yaw = accel_left_q == CntOne;
  end

  imc_sensor_cal u_gyro_cal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (gyro_ctrl),
    .axis_i (gyro_axis),
    .cal_o  (gyro_st)
  );

  imc_sensor_cal u_accel_cal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (accel_ctrl),
    .axis_i (accel_axis),
    .cal_o  (accel_st)
  );

  always_comb begin
    gyro_left_d  = gyro_left_q;
    accel_left_d = accel_left_q;
    res_axis     = '0;
    case (in_q.op)
      imc_pkg::OP_GYRO: begin
        if (gyro_cal) begin
          gyro_left_d = gyro_left_q - CntOne;
          res_axis    = gyro_axis;
        end else begin
          for (int i = 0; i < imc_pkg::NUM_AXES; i++) begin
            res_axis[i] = gyro_axis[i] - gyro_st.offset[i];
          end
        end
      end
      imc_pkg::OP_ACCEL: begin
        if (accel_cal) begin
          accel_left_d = accel_left_q - CntOne;
          for (int i = 0; i < imc_pkg::NUM_AXES; i++) begin
            res_axis[i] = accel_axis[i] - accel_st.offset_upd[i];
          end
        end else begin
          for (int i = 0; i < imc_pkg::NUM_AXES; i++) begin
            res_axis[i] = accel_axis[i] - accel_st.offset[i];
          end
        end
      end
      imc_pkg::OP_START_ALL: begin
        gyro_left_d  = CalLoad;
        accel_left_d = CalLoad;
      end
      imc_pkg::OP_START_ACCEL: begin
        accel_left_d = CalLoad;
      end
      default: begin
        res_axis = '0;
      end
    endcase
    out_d.roll_value     = res_axis[0];
    out_d.pitch_value    = res_axis[1];
    out_d.yaw_value      = res_axis[2];
    out_d.gyro_cal_done  = gyro_left_d == '0;
    out_d.accel_cal_done = accel_left_d == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_left_q  <= CalLoad;
      accel_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s1_fire) begin
        gyro_left_q  <= gyro_left_d;
        accel_left_q <= accel_left_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_gyro_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gyro_left_q <= CalLoad)
    else $error("gyro sample counter above calibration length");

  a_accel_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accel_left_q <= CalLoad)
    else $error("accel sample counter above calibration length");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q)
    else $error("input stage item lost while result register full");

  a_start_clears_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (in_q.op == imc_pkg::OP_START_ALL)
    |=> out_valid_o && !out_data_o.gyro_cal_done && !out_data_o.accel_cal_done)
    else $error("start of both calibrations reported as done");
`endif

endmodule
